[rtl/assert_macros.svh]
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every clock edge outside reset.
`define LSS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define LSS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/lss_pkg.sv]
`default_nettype none

package lss_pkg;

  localparam int unsigned DEPTH_DEF = 16;
  localparam int unsigned WORD_W    = 32;
  localparam int unsigned CNT_W     = 5;

  typedef enum logic [1:0] {
    REQ_PUSH   = 2'd0,
    REQ_POP    = 2'd1,
    REQ_PEEK   = 2'd2,
    REQ_SEARCH = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_UNDER = 2'd1,
    ST_OVER  = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_SCAN,
    S_DONE
  } back_state_t;

  typedef struct packed {
    logic [1:0]               req_type;
    logic signed [WORD_W-1:0] value;
  } in_t;

  typedef struct packed {
    logic signed [WORD_W-1:0] data_out;
    logic                     found;
    logic [CNT_W-1:0]         entry_count;
    logic [1:0]               status;
  } out_t;

  typedef struct packed {
    req_t              op;
    logic [WORD_W-1:0] value;
  } q_item_t;

  // front to back: head of the request queue
  typedef struct packed {
    logic    valid;
    q_item_t item;
  } q_head_t;

endpackage

`default_nettype wire

[rtl/lss_ram.sv]
`default_nettype none

module lss_ram #(
  parameter int unsigned WIDTH = lss_pkg::WORD_W,
  parameter int unsigned DEPTH = lss_pkg::DEPTH_DEF
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

[rtl/lss_front.sv]
`default_nettype none

`include "assert_macros.svh"

module lss_front (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  output logic                in_stall,
  input  wire lss_pkg::in_t   in_data,
  output lss_pkg::q_head_t    q_head,
  input  wire logic           q_take
);

  lss_pkg::q_item_t q_r [2];
  logic             wr_ptr_r, wr_ptr_nxt;
  logic             rd_ptr_r, rd_ptr_nxt;
  logic [1:0]       cnt_r, cnt_nxt;
  logic             accept;
  lss_pkg::q_item_t item;

  assign in_stall = (cnt_r == 2'd2);
  assign accept   = in_valid && !in_stall;

  // classify the request code
  always_comb begin
    item.value = in_data.value;
    case (in_data.req_type)
      lss_pkg::REQ_PUSH: item.op = lss_pkg::REQ_PUSH;
      lss_pkg::REQ_POP:  item.op = lss_pkg::REQ_POP;
      lss_pkg::REQ_PEEK: item.op = lss_pkg::REQ_PEEK;
      default:           item.op = lss_pkg::REQ_SEARCH;
    endcase
  end

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (accept) begin
      wr_ptr_nxt = !wr_ptr_r;
    end
    if (q_take) begin
      rd_ptr_nxt = !rd_ptr_r;
    end
    if (accept && !q_take) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (!accept && q_take) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      q_r[wr_ptr_r] <= item;
    end
  end

  assign q_head.valid = (cnt_r != 2'd0);
  assign q_head.item  = q_r[rd_ptr_r];

  `LSS_ASSERT(a_take_nonempty, q_take |-> (cnt_r != 2'd0), "queue read while empty")
  `LSS_ASSERT(a_cnt_grows,
              (accept && !q_take) |=> (cnt_r == $past(cnt_r) + 2'd1),
              "queue count lost a beat")

endmodule

`default_nettype wire

[rtl/lss_back.sv]
`default_nettype none

`include "assert_macros.svh"

module lss_back #(
  parameter int unsigned DEPTH = lss_pkg::DEPTH_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire lss_pkg::q_head_t q_head,
  output logic                  q_take,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output lss_pkg::out_t         out_data
);

  localparam int unsigned IW = $clog2(DEPTH);
  localparam int unsigned FW = $clog2(DEPTH + 1);

  lss_pkg::back_state_t state_r, state_nxt;
  logic [FW-1:0]        fill_r, fill_nxt;
  logic [FW-1:0]        fill_m1, fill_p1;
  logic [lss_pkg::WORD_W-1:0] value_r, value_nxt;
  logic [IW-1:0]        scan_idx_r, scan_idx_nxt;
  logic                 issued_all_r, issued_all_nxt;
  logic                 cmp_vld_r, cmp_vld_nxt;
  logic                 cmp_last_r, cmp_last_nxt;
  lss_pkg::out_t        res_r, res_nxt;
  lss_pkg::out_t        out_r, out_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic                 out_free;
  logic                 full, empty;
  logic                 ram_we;
  logic [IW-1:0]        rd_addr;
  logic [lss_pkg::WORD_W-1:0] rd_data;

  function automatic logic [lss_pkg::CNT_W-1:0] to_cnt(input logic [FW-1:0] f);
    logic [FW+lss_pkg::CNT_W-1:0] ext;
    ext    = {{lss_pkg::CNT_W{1'b0}}, f};
    to_cnt = ext[lss_pkg::CNT_W-1:0];
  endfunction

  assign fill_m1  = fill_r - FW'(1);
  assign fill_p1  = fill_r + FW'(1);
  assign full     = (fill_r == FW'(DEPTH));
  assign empty    = (fill_r == '0);
  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt      = state_r;
    fill_nxt       = fill_r;
    value_nxt      = value_r;
    scan_idx_nxt   = scan_idx_r;
    issued_all_nxt = issued_all_r;
    cmp_vld_nxt    = 1'b0;
    cmp_last_nxt   = cmp_last_r;
    res_nxt        = res_r;
    out_nxt        = out_r;
    out_valid_nxt  = out_valid_r && out_stall;
    q_take         = 1'b0;
    ram_we         = 1'b0;
    rd_addr        = scan_idx_r;

    case (state_r)
      lss_pkg::S_IDLE: begin
        rd_addr = fill_m1[IW-1:0];
        if (q_head.valid) begin
          q_take              = 1'b1;
          value_nxt           = q_head.item.value;
          res_nxt             = '0;
          res_nxt.entry_count = to_cnt(fill_r);
          res_nxt.status      = lss_pkg::ST_OK;
          state_nxt           = lss_pkg::S_DONE;
          case (q_head.item.op)
            lss_pkg::REQ_PUSH: begin
              if (full) begin
                res_nxt.status = lss_pkg::ST_OVER;
              end else begin
                ram_we              = 1'b1;
                fill_nxt            = fill_p1;
                res_nxt.entry_count = to_cnt(fill_p1);
              end
            end
            lss_pkg::REQ_POP: begin
              if (empty) begin
                res_nxt.status = lss_pkg::ST_UNDER;
              end else begin
                fill_nxt            = fill_m1;
                res_nxt.entry_count = to_cnt(fill_m1);
                state_nxt           = lss_pkg::S_READ;
              end
            end
            lss_pkg::REQ_PEEK: begin
              if (empty) begin
                res_nxt.status = lss_pkg::ST_UNDER;
              end else begin
                state_nxt = lss_pkg::S_READ;
              end
            end
            lss_pkg::REQ_SEARCH: begin
              if (!empty) begin
                scan_idx_nxt   = '0;
                issued_all_nxt = 1'b0;
                state_nxt      = lss_pkg::S_SCAN;
              end
            end
            default: ;
          endcase
        end
      end
      lss_pkg::S_READ: begin
        res_nxt.data_out = rd_data;
        state_nxt        = lss_pkg::S_DONE;
      end
      lss_pkg::S_SCAN: begin
        // one read issued per cycle, compared on the next
        if (!issued_all_r) begin
          cmp_vld_nxt  = 1'b1;
          cmp_last_nxt = (scan_idx_r == fill_m1[IW-1:0]);
          if (scan_idx_r == fill_m1[IW-1:0]) begin
            issued_all_nxt = 1'b1;
          end else begin
            scan_idx_nxt = scan_idx_r + IW'(1);
          end
        end
        if (cmp_vld_r && (rd_data == value_r)) begin
          res_nxt.found = 1'b1;
          state_nxt     = lss_pkg::S_DONE;
        end else if (cmp_vld_r && cmp_last_r) begin
          state_nxt = lss_pkg::S_DONE;
        end
      end
      lss_pkg::S_DONE: begin
        if (out_free) begin
          out_nxt       = res_r;
          out_valid_nxt = 1'b1;
          state_nxt     = lss_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = lss_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= lss_pkg::S_IDLE;
      fill_r       <= '0;
      issued_all_r <= 1'b0;
      cmp_vld_r    <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      fill_r       <= fill_nxt;
      issued_all_r <= issued_all_nxt;
      cmp_vld_r    <= cmp_vld_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    value_r    <= value_nxt;
    scan_idx_r <= scan_idx_nxt;
    cmp_last_r <= cmp_last_nxt;
    res_r      <= res_nxt;
    out_r      <= out_nxt;
  end

  lss_ram #(
    .WIDTH (lss_pkg::WORD_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk     (clk),
    .we      (ram_we),
    .wr_addr (fill_r[IW-1:0]),
    .wr_data (q_head.item.value),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  `LSS_ASSERT(a_fill_bound, fill_r <= FW'(DEPTH), "fill level beyond depth")
  `LSS_ASSERT(a_scan_nonempty,
              (state_r == lss_pkg::S_SCAN) |-> !empty,
              "search walk on empty store")
  `LSS_ASSERT(a_read_after_idle,
              (state_r == lss_pkg::S_READ) |-> ($past(state_r) == lss_pkg::S_IDLE),
              "read stage entered out of turn")

endmodule

`default_nettype wire

[rtl/lifo_stack_with_search.sv]
`default_nettype none

// Bounded LIFO of signed 32-bit words with push, pop, peek and search requests; one
// result beat per request beat, in order. A two-beat request queue decouples the input
// from the executing back end, so requests are taken while a result waits on out_stall.
// Path through the back end: push, errors and empty search go from idle to done; pop/peek
// pass a read state for the registered store read; search walks the store through its
// single read port, one entry per cycle, until a hit or the last entry. A pop or peek of
// an empty stack returns status underflow with data 0; a push onto a full stack is
// dropped with status overflow. entry_count is the fill level after the request, low
// five bits. No clearing pass after reset.
module lifo_stack_with_search #(
  parameter int unsigned DEPTH = lss_pkg::DEPTH_DEF
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_valid,
  output logic              in_stall,
  input  wire lss_pkg::in_t in_data,
  output logic              out_valid,
  input  wire logic         out_stall,
  output lss_pkg::out_t     out_data
);

  lss_pkg::q_head_t q_head;
  logic             q_take;

  lss_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .q_head   (q_head),
    .q_take   (q_take)
  );

  lss_back #(
    .DEPTH (DEPTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_head    (q_head),
    .q_take    (q_take),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

[tb/lifo_stack_with_search_tb.sv]
`default_nettype none

module lifo_stack_with_search_tb;

  localparam int STACK_DEPTH = lss_pkg::DEPTH_DEF;
  localparam int RAND_ITEMS  = 550;
  localparam int TAIL_CYCLES = 25;
  localparam int MAX_CYCLES  = 400000;
  localparam int LONG_HOLD   = 60;

  typedef struct packed {
    logic         drain;  // wait for every outstanding result before offering this beat
    lss_pkg::in_t beat;
  } stim_t;

  logic          clk = 1'b0;
  logic          rst_n = 1'b0;
  logic          in_valid = 1'b0;
  logic          in_stall;
  lss_pkg::in_t  in_data = '0;
  logic          out_valid;
  logic          out_stall = 1'b0;
  lss_pkg::out_t out_data;

  lifo_stack_with_search u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // shadow of the stack
  logic [lss_pkg::WORD_W-1:0] stk_words [STACK_DEPTH];
  int                         stk_fill = 0;

  stim_t         req_q[$];
  lss_pkg::out_t predicted_results[$];

  int  err_cnt = 0;
  int  cycle_cnt = 0;
  int  results_seen = 0;
  int  n_under = 0;
  int  n_over = 0;
  int  n_hits = 0;
  int  n_full = 0;
  int  n_in_blocked = 0;
  int  send_gap = 0;
  int  stall_left = 0;
  bit  long_hold_done = 1'b0;
  bit  beat_taken = 1'b0;
  logic          nxt_valid;
  lss_pkg::out_t exp_r;
  logic [lss_pkg::WORD_W-1:0] pool [8];

  function automatic lss_pkg::out_t apply_request(lss_pkg::in_t b);
    lss_pkg::out_t r;
    r = '0;
    case (lss_pkg::req_t'(b.req_type))
      lss_pkg::REQ_PUSH: begin
        if (stk_fill >= STACK_DEPTH) begin
          r.status = lss_pkg::ST_OVER;
        end else begin
          stk_words[stk_fill] = b.value;
          stk_fill++;
        end
      end
      lss_pkg::REQ_POP: begin
        if (stk_fill == 0) begin
          r.status = lss_pkg::ST_UNDER;
        end else begin
          stk_fill--;
          r.data_out = stk_words[stk_fill];
        end
      end
      lss_pkg::REQ_PEEK: begin
        if (stk_fill == 0) r.status = lss_pkg::ST_UNDER;
        else r.data_out = stk_words[stk_fill-1];
      end
      default: begin
        for (int i = 0; i < stk_fill; i++)
          if (stk_words[i] == b.value) r.found = 1'b1;
      end
    endcase
    r.entry_count = lss_pkg::CNT_W'(stk_fill);
    return r;
  endfunction

  // mostly short gaps, a few long ones; none at all in some stretches
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (cycle_cnt[9:8] == 2'b00) return 0;
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic void add_req(lss_pkg::req_t op, logic [lss_pkg::WORD_W-1:0] v,
                                  bit drain);
    stim_t s;
    s.drain         = drain;
    s.beat.req_type = op;
    s.beat.value    = v;
    req_q.push_back(s);
  endfunction

  function automatic void check_field(string name, logic [lss_pkg::WORD_W-1:0] e,
                                      logic [lss_pkg::WORD_W-1:0] a);
    if (e !== a) begin
      err_cnt++;
      $display("%0t: %s expected %0h actual %0h", $time, name, e, a);
    end
  endfunction

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > MAX_CYCLES) begin
      $display("Timeout after %0d cycles", cycle_cnt);
      $display("Mismatches found");
      $finish;
    end
  end

  // monitor: check the result beat, then record the accepted request
  always @(posedge clk) begin
    beat_taken = rst_n && in_valid && !in_stall;
    if (rst_n && in_valid && in_stall) n_in_blocked++;
    if (rst_n && out_valid && !out_stall) begin
      if (predicted_results.size() == 0) begin
        err_cnt++;
        $display("%0t: unexpected result beat, expected none actual %0h", $time, out_data);
      end else begin
        exp_r = predicted_results.pop_front();
        check_field("data_out", exp_r.data_out, out_data.data_out);
        check_field("found", exp_r.found, out_data.found);
        check_field("entry_count", exp_r.entry_count, out_data.entry_count);
        check_field("status", exp_r.status, out_data.status);
        results_seen++;
        if (exp_r.status == lss_pkg::ST_UNDER) n_under++;
        if (exp_r.status == lss_pkg::ST_OVER) n_over++;
        if (exp_r.found) n_hits++;
        if (exp_r.entry_count == lss_pkg::CNT_W'(STACK_DEPTH)) n_full++;
      end
    end
    if (beat_taken) predicted_results.push_back(apply_request(in_data));
  end

  // driver
  always @(negedge clk) begin
    if (rst_n) begin
      if (in_valid && beat_taken) void'(req_q.pop_front());
      nxt_valid = in_valid && !beat_taken;
      if (!nxt_valid) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (req_q.size() > 0 &&
                     (!req_q[0].drain || predicted_results.size() == 0)) begin
          nxt_valid = 1'b1;
          send_gap  = pick_gap();
        end
      end
      in_valid <= nxt_valid;
      if (nxt_valid) in_data <= req_q[0].beat;
    end
  end

  // receiver stalls; one long hold part way through lets the request queue back up
  always @(negedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (!long_hold_done && results_seen >= 150) begin
      long_hold_done = 1'b1;
      stall_left     = LONG_HOLD - 1;
      out_stall     <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
      stall_left = pick_gap();
    end
  end

  initial begin
    int            seg_left;
    int            mode;
    int            r;
    lss_pkg::req_t op;
    logic [lss_pkg::WORD_W-1:0] v;

    seg_left = 0;
    mode     = 0;
    pool[0] = 32'h7fff_ffff;
    pool[1] = 32'h8000_0000;
    pool[2] = 32'h0000_0000;
    pool[3] = 32'hffff_ffff;
    for (int i = 4; i < 8; i++) pool[i] = $urandom;

    // directed: empty cases, fill to the top, overflow, searches for the bottom entry and a missing word
    add_req(lss_pkg::REQ_POP, 32'h0, 1'b0);
    add_req(lss_pkg::REQ_PEEK, 32'hffff_ffff, 1'b0);
    add_req(lss_pkg::REQ_SEARCH, 32'h0, 1'b0);
    add_req(lss_pkg::REQ_PUSH, 32'h7fff_ffff, 1'b0);
    add_req(lss_pkg::REQ_PUSH, 32'h8000_0000, 1'b0);
    add_req(lss_pkg::REQ_PUSH, 32'h0000_0000, 1'b0);
    add_req(lss_pkg::REQ_PUSH, 32'hffff_ffff, 1'b0);
    add_req(lss_pkg::REQ_PUSH, 32'h0000_0001, 1'b0);
    add_req(lss_pkg::REQ_PUSH, 32'h5555_5555, 1'b0);
    add_req(lss_pkg::REQ_PUSH, 32'haaaa_aaaa, 1'b0);
    for (int i = 0; i < 9; i++) add_req(lss_pkg::REQ_PUSH, $urandom, 1'b0);
    add_req(lss_pkg::REQ_PUSH, 32'h1234_5678, 1'b0);
    add_req(lss_pkg::REQ_SEARCH, 32'h7fff_ffff, 1'b0);
    add_req(lss_pkg::REQ_SEARCH, 32'h7fff_fffe, 1'b0);
    add_req(lss_pkg::REQ_PEEK, 32'h0, 1'b0);
    add_req(lss_pkg::REQ_POP, 32'h0, 1'b0);
    add_req(lss_pkg::REQ_SEARCH, 32'haaaa_aaaa, 1'b1);

    // random: segments biased towards filling, draining or neither
    for (int n = 0; n < RAND_ITEMS; n++) begin
      if (seg_left == 0) begin
        mode     = $urandom_range(0, 2);
        seg_left = $urandom_range(15, 60);
      end
      seg_left--;
      r = $urandom_range(0, 99);
      case (mode)
        0: op = (r < 65) ? lss_pkg::REQ_PUSH : (r < 75) ? lss_pkg::REQ_POP
              : (r < 85) ? lss_pkg::REQ_PEEK : lss_pkg::REQ_SEARCH;
        1: op = (r < 20) ? lss_pkg::REQ_PUSH : (r < 65) ? lss_pkg::REQ_POP
              : (r < 78) ? lss_pkg::REQ_PEEK : lss_pkg::REQ_SEARCH;
        default: op = (r < 40) ? lss_pkg::REQ_PUSH : (r < 65) ? lss_pkg::REQ_POP
                    : (r < 78) ? lss_pkg::REQ_PEEK : lss_pkg::REQ_SEARCH;
      endcase
      // pool words make search hits likely
      v = ($urandom_range(0, 1) == 1) ? pool[$urandom_range(0, 7)] : $urandom;
      add_req(op, v, (n % 97) == 50);
    end

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    while (req_q.size() > 0 || in_valid) @(posedge clk);
    while (predicted_results.size() > 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Checked %0d results: %0d underflow, %0d overflow, %0d search hits",
             results_seen, n_under, n_over, n_hits);
    $display("Full stack seen %0d times, input held off for %0d cycles",
             n_full, n_in_blocked);
    if (err_cnt == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

`default_nettype wire
